@@ hw/rtl/charger_dongle_capability_probe_macros.svh @@
// ----------------------------------------------------------------------------
// Charger dongle capability probe - assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef CHARGER_DONGLE_CAPABILITY_PROBE_MACROS_SVH
`define CHARGER_DONGLE_CAPABILITY_PROBE_MACROS_SVH

// Same-cycle implication
`define DCP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define DCP_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/dcp_pkg.sv @@
// ----------------------------------------------------------------------------
// dcp_pkg
// Types and constants shared by the capability probe modules.
// ----------------------------------------------------------------------------
package dcp_pkg;

  // Item kinds (input tuser)
  typedef enum logic [1:0] {
    KIND_TICK   = 2'd0,
    KIND_ATTACH = 2'd1,
    KIND_POWER  = 2'd2,
    KIND_READ   = 2'd3
  } kind_t;

  // Probe sequencer phases, one-hot
  typedef enum logic [4:0] {
    PH_IDLE   = 5'b00001,
    PH_POLL   = 5'b00010,
    PH_WINDOW = 5'b00100,
    PH_PULSE  = 5'b01000,
    PH_HOLD   = 5'b10000
  } phase_t;

  // Pin modes
  localparam logic [1:0] MODE_RELEASED = 2'd0;
  localparam logic [1:0] MODE_PULLUP   = 2'd1;
  localparam logic [1:0] MODE_LOW      = 2'd2;

  // Attach values
  localparam logic [1:0] ATT_ATTACHED = 2'd0;
  localparam logic [1:0] ATT_DETACHED = 2'd1;
  localparam logic [1:0] ATT_INVALID  = 2'd2;
  localparam logic [1:0] ATT_UNUSED   = 2'd3;

  // Power events
  localparam logic [1:0] PWR_NONE  = 2'd0;
  localparam logic [1:0] PWR_GOOD  = 2'd1;
  localparam logic [1:0] PWR_FAULT = 2'd2;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_POLL_LIMIT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_WINDOW = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD         = 3'd4;

  // Register reset values
  localparam logic [7:0]  RST_POLL_LIMIT   = 8'd100;
  localparam logic [15:0] RST_FIRST_WINDOW = 16'd200;
  localparam logic [15:0] RST_PULSE        = 16'd10;
  localparam logic [15:0] RST_WINDOW       = 16'd100;
  localparam logic [15:0] RST_HOLD         = 16'd1000;

  // Detected currents and reported voltage
  localparam logic [11:0] MA_NONE = 12'd0;
  localparam logic [11:0] MA_500  = 12'd500;
  localparam logic [11:0] MA_1500 = 12'd1500;
  localparam logic [11:0] MA_3000 = 12'd3000;
  localparam logic [12:0] MV_5000 = 13'd5000;

  // Stream data widths in bits
  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned OUT_DATA_W = 32;

  typedef struct packed {
    kind_t      kind;
    logic       pin_level;
    logic [1:0] attach_value;
    logic [1:0] power_event;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  pin_mode;
    logic [11:0] current_ma;
    logic [12:0] voltage_mv;
    logic        notify;
    logic        busy_res;
    logic        rejected;
  } out_item_t;

endpackage

@@ hw/rtl/charger_dongle_capability_probe.sv @@
// ----------------------------------------------------------------------------
// charger_dongle_capability_probe
// Attach/power tracking and timed one-wire capability probe, stream wrapper.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel in_*: one word per tick (100 us), attach event, power event
//   or read request; the kind travels in in_tuser. Master channel out_*: one
//   result word per input word, in order, with pin mode, current, voltage,
//   notify, busy and rejected flags.
//   Path: an accepted word passes two register stages, the input word register
//   and then the result register, before its result shows on out_*.
//   Throughput: one word per cycle unless the receiver stalls; the whole step
//   is one pass through the sequencer logic between the two registers.
//   If the receiver stalls, one more word is still taken into the input
//   register; after that in_tready drops until out_tready returns.
//   Reset (rst_n low, synchronous) empties both registers, loads the config
//   defaults and returns the probe to idle with attach invalid and no power.
//   Config writes (cfg_we/cfg_index/cfg_data) take effect at the next edge
//   and are meant for when the block is idle.
// ----------------------------------------------------------------------------
module charger_dongle_capability_probe import dcp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // pin_level, attach_value[1:0], power_event[1:0]
  input  logic [1:0]            in_tuser,   // kind
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // pin_mode[1:0], current_ma[11:0], voltage_mv[12:0], notify, busy_res, rejected
  output logic [OUT_DATA_W-1:0] out_tdata
);

  in_item_t  in_item, held_item;
  out_item_t res, out_item;
  logic      held_valid, out_free, fire;

  // Unpack slave word
  always_comb begin
    in_item.kind         = kind_t'(in_tuser);
    in_item.pin_level    = in_tdata[0];
    in_item.attach_value = in_tdata[2:1];
    in_item.power_event  = in_tdata[4:3];
  end

  assign fire = held_valid && out_free;

  dcp_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_item    (in_item),
    .take       (fire),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  dcp_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fire      (fire),
    .item      (held_item),
    .res       (res)
  );

  dcp_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (fire),
    .res       (res),
    .free      (out_free),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_item  (out_item)
  );

  // Pack master word
  assign out_tdata = {2'b00, out_item.rejected, out_item.busy_res, out_item.notify,
                      out_item.voltage_mv, out_item.current_ma, out_item.pin_mode};

endmodule

@@ hw/rtl/dcp_in_stage.sv @@
// ----------------------------------------------------------------------------
// dcp_in_stage
// Input word register; holds one word while the engine waits for the output.
// ----------------------------------------------------------------------------
module dcp_in_stage import dcp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_item,
  input  logic     take,       // engine consumes the held word
  output logic     held_valid,
  output in_item_t held_item
);

  logic     valid_r;
  in_item_t item_r;

  assign in_ready   = !valid_r || take;
  assign held_valid = valid_r;
  assign held_item  = item_r;

  // Valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

@@ hw/rtl/dcp_engine.sv @@
// ----------------------------------------------------------------------------
// dcp_engine
// Config registers, attach/power state and the tick-driven probe sequencer.
// ----------------------------------------------------------------------------
`include "charger_dongle_capability_probe_macros.svh"

module dcp_engine import dcp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  fire,
  input  in_item_t              item,
  output out_item_t             res
);

  // Config registers
  logic [7:0]  poll_lim_r;
  logic [15:0] first_win_r, pulse_r, win_r, hold_r;

  // Block state
  logic [1:0]  attach_r, attach_nxt;
  logic [1:0]  power_r, power_nxt;
  logic [11:0] found_r, found_nxt;
  phase_t      phase_r, phase_nxt;
  logic [15:0] timer_r, timer_nxt;
  logic [1:0]  stage_r, stage_nxt;

  logic        busy;
  logic [1:0]  att;
  logic [15:0] t_inc;
  logic [15:0] win_tgt, win_tgt1, pulse_tgt1, hold_tgt;
  logic [11:0] stage_ma;
  logic        changed;
  logic        notify;
  logic        rejected;
  logic [11:0] cur;
  logic [12:0] volt;

  assign busy       = (phase_r != PH_IDLE);
  assign att        = (item.attach_value == ATT_UNUSED) ? ATT_INVALID : item.attach_value;
  assign t_inc      = timer_r + 16'd1;
  assign win_tgt    = (stage_r == 2'd0) ? first_win_r : win_r;
  assign win_tgt1   = (win_tgt == 16'd0) ? 16'd1 : win_tgt;
  assign pulse_tgt1 = (pulse_r == 16'd0) ? 16'd1 : pulse_r;
  assign hold_tgt   = (found_r != MA_NONE) ? hold_r : 16'd0;
  assign stage_ma   = (stage_r == 2'd0) ? MA_500 : ((stage_r == 2'd1) ? MA_1500 : MA_3000);

  // Next state for one word
  always_comb begin
    attach_nxt = attach_r;
    power_nxt  = power_r;
    found_nxt  = found_r;
    phase_nxt  = phase_r;
    timer_nxt  = timer_r;
    stage_nxt  = stage_r;
    changed    = 1'b0;
    notify     = 1'b0;
    rejected   = 1'b0;
    cur        = MA_NONE;
    volt       = 13'd0;

    case (item.kind)
      KIND_TICK: begin
        case (phase_r)
          PH_POLL: begin
            if (item.pin_level) begin
              phase_nxt = PH_WINDOW;
              timer_nxt = 16'd0;
              stage_nxt = 2'd0;
            end else if (t_inc >= {8'd0, poll_lim_r}) begin
              found_nxt = MA_NONE;
              phase_nxt = PH_HOLD;
              timer_nxt = 16'd0;
            end else begin
              timer_nxt = t_inc;
            end
          end
          PH_WINDOW: begin
            if (t_inc < win_tgt1) begin
              timer_nxt = t_inc;
            end else if (!item.pin_level) begin
              found_nxt = stage_ma;
              phase_nxt = PH_HOLD;
              timer_nxt = 16'd0;
            end else if (stage_r >= 2'd2) begin
              found_nxt = MA_NONE;
              phase_nxt = PH_HOLD;
              timer_nxt = 16'd0;
            end else begin
              stage_nxt = stage_r + 2'd1;
              phase_nxt = PH_PULSE;
              timer_nxt = 16'd0;
            end
          end
          PH_PULSE: begin
            if (t_inc >= pulse_tgt1) begin
              phase_nxt = PH_WINDOW;
              timer_nxt = 16'd0;
            end else begin
              timer_nxt = t_inc;
            end
          end
          PH_HOLD: begin
            if (timer_r >= hold_tgt) begin
              phase_nxt = PH_IDLE;
              timer_nxt = 16'd0;
              stage_nxt = 2'd0;
              notify    = 1'b1;
            end else begin
              timer_nxt = t_inc;
            end
          end
          default: begin
            phase_nxt = PH_IDLE;
          end
        endcase
      end
      KIND_READ: begin
        if (attach_r == ATT_DETACHED && power_r == PWR_GOOD && found_r != MA_NONE) begin
          cur  = found_r;
          volt = MV_5000;
        end
      end
      KIND_ATTACH: begin
        if (busy) begin
          rejected = 1'b1;
        end else if (att != attach_r) begin
          found_nxt  = MA_NONE;
          attach_nxt = att;
          changed    = 1'b1;
        end
      end
      default: begin
        // power event
        if (busy) begin
          rejected = 1'b1;
        end else begin
          found_nxt = MA_NONE;
          if (power_r != PWR_FAULT && power_r != item.power_event) begin
            power_nxt = item.power_event;
            changed   = 1'b1;
          end
        end
      end
    endcase

    // State change: start a probe or notify at once
    if (changed) begin
      if (power_nxt == PWR_GOOD && attach_nxt == ATT_DETACHED) begin
        phase_nxt = PH_POLL;
        timer_nxt = 16'd0;
        stage_nxt = 2'd0;
      end else begin
        notify = 1'b1;
      end
    end
  end

  // Result word
  always_comb begin
    res.current_ma = cur;
    res.voltage_mv = volt;
    res.notify     = notify;
    res.rejected   = rejected;
    res.busy_res   = (phase_nxt != PH_IDLE);
    case (phase_nxt)
      PH_POLL, PH_WINDOW: res.pin_mode = MODE_PULLUP;
      PH_PULSE, PH_HOLD:  res.pin_mode = MODE_LOW;
      default:            res.pin_mode = MODE_RELEASED;
    endcase
  end

  // Config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poll_lim_r  <= RST_POLL_LIMIT;
      first_win_r <= RST_FIRST_WINDOW;
      pulse_r     <= RST_PULSE;
      win_r       <= RST_WINDOW;
      hold_r      <= RST_HOLD;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_POLL_LIMIT:   poll_lim_r  <= cfg_data[7:0];
        CFG_FIRST_WINDOW: first_win_r <= cfg_data;
        CFG_PULSE:        pulse_r     <= cfg_data;
        CFG_WINDOW:       win_r       <= cfg_data;
        CFG_HOLD:         hold_r      <= cfg_data;
        default:          ;
      endcase
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attach_r <= ATT_INVALID;
      power_r  <= PWR_NONE;
      found_r  <= MA_NONE;
      phase_r  <= PH_IDLE;
      timer_r  <= 16'd0;
      stage_r  <= 2'd0;
    end else if (fire) begin
      attach_r <= attach_nxt;
      power_r  <= power_nxt;
      found_r  <= found_nxt;
      phase_r  <= phase_nxt;
      timer_r  <= timer_nxt;
      stage_r  <= stage_nxt;
    end
  end

  // Checks
  `DCP_ASSERT_NXT(a_reject_keeps_state, fire && rejected,
    $stable(attach_r) && $stable(power_r) && $stable(found_r), "rejected event changed state")
  `DCP_ASSERT_NXT(a_notify_ends_idle, fire && notify, phase_r == PH_IDLE,
    "notify raised while probe still running")
  `DCP_ASSERT_IMP(a_found_legal, found_r != MA_NONE,
    found_r == MA_500 || found_r == MA_1500 || found_r == MA_3000, "illegal found current")
  `DCP_ASSERT_IMP(a_idle_timer_clear, phase_r == PH_IDLE, timer_r == 16'd0,
    "timer not cleared in idle")

endmodule

@@ hw/rtl/dcp_out_stage.sv @@
// ----------------------------------------------------------------------------
// dcp_out_stage
// Result word register toward the master side.
// ----------------------------------------------------------------------------
module dcp_out_stage import dcp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      load,
  input  out_item_t res,
  output logic      free,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  logic      valid_r;
  out_item_t item_r;

  assign free      = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_item  = item_r;

  // Valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (free) begin
      valid_r <= load;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= res;
    end
  end

endmodule
